// ===== design/palette_nearest_color_search_top_assert.svh =====
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef PALETTE_NEAREST_COLOR_SEARCH_TOP_ASSERT_SVH
`define PALETTE_NEAREST_COLOR_SEARCH_TOP_ASSERT_SVH

// same-cycle implication
`define PNCS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pncs check failed");

// next-cycle implication
`define PNCS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pncs check failed");

`endif

// ===== design/pncs_pkg.sv =====
package pncs_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

	localparam int OP_W = 2;
	localparam int IDX_W = 8;
	localparam int COMP_W = 8;
	localparam int RGB_W = 3 * COMP_W;
	localparam int SQ_W = 2 * COMP_W;
	localparam int DIST_W = 18;

	localparam int IN_DATA_W = IDX_W + RGB_W;
	localparam int OUT_RAW_W = IDX_W + RGB_W + DIST_W;
	localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

	localparam logic [COMP_W-1:0] COMP_MASK = 8'hFC;
	localparam logic [PAL_AW-1:0] LAST_ENTRY = PAL_AW'(PALETTE_ENTRIES - 1);

endpackage

// ===== design/palette_nearest_color_search_top.sv =====
// channel   dir  signals                       contents
// s_        in   s_tvalid s_tready s_tdata     request: entry_index, red, green, blue; tuser op
// m_        out  m_tvalid m_tready m_tdata     result: index, color, distance
//
// a write is stored at its request handshake; a lookup passes the palette read register, then the output register
// a search reads one palette entry per cycle from the single read port,
// then passes the distance stage and the best-match registers before the output register
// lookup and search keep s_tready low until their result enters the output register
// after reset every entry reads as zero through per-entry valid flops
// a finished result waits in the output register while the next request is taken
`include "palette_nearest_color_search_top_assert.svh"

module palette_nearest_color_search_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// entry_index, red, green, blue (lowest bits first)
	input  logic [pncs_pkg::IN_DATA_W-1:0]   s_tdata,
	// op
	input  logic [pncs_pkg::OP_W-1:0]        s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// found_index, out_red, out_green, out_blue, distance (lowest bits first), zero fill
	output logic [pncs_pkg::OUT_DATA_W-1:0]  m_tdata
);

	import pncs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_SEARCH,
		ST_DRAIN,
		ST_DONE
	} state_t;

	function automatic logic [SQ_W-1:0] sq_dist(input logic [COMP_W-1:0] a,
			input logic [COMP_W-1:0] b);
		logic [COMP_W-1:0] d;
		d = (a >= b) ? (a - b) : (b - a);
		return SQ_W'(d) * SQ_W'(d);
	endfunction

	state_t state_q;
	logic m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic acc;
	logic [OP_W-1:0] in_op;
	logic [IDX_W-1:0] in_idx;
	logic [COMP_W-1:0] in_r, in_g, in_b;
	logic in_range;
	logic out_free;
	logic out_load;

	logic ram_we, ram_re;
	logic [PAL_AW-1:0] ram_raddr;
	logic [RGB_W-1:0] ram_wdata, ram_rdata;

	logic [PALETTE_ENTRIES-1:0] vld_q;
	logic [PAL_AW-1:0] cnt_q;
	logic [IDX_W-1:0] look_idx_q;
	logic look_in_q;
	logic [COMP_W-1:0] key_r_q, key_g_q, key_b_q;

	logic vld_s1, act_s1, last_s1;
	logic [PAL_AW-1:0] idx_s1;
	logic [RGB_W-1:0] pal_s1;

	logic act_s2, last_s2;
	logic [PAL_AW-1:0] idx_s2;
	logic [RGB_W-1:0] rgb_s2;
	logic [SQ_W-1:0] sqr_s2, sqg_s2, sqb_s2;
	logic [DIST_W-1:0] sum_s2;

	logic first_q;
	logic [DIST_W-1:0] best_dist_q;
	logic [PAL_AW-1:0] best_idx_q;
	logic [RGB_W-1:0] best_rgb_q;

	assign s_tready = (state_q == ST_IDLE);
	assign acc = s_tvalid && s_tready;
	assign in_op = s_tuser;
	assign in_idx = s_tdata[IDX_W-1:0];
	assign in_r = s_tdata[IDX_W +: COMP_W];
	assign in_g = s_tdata[IDX_W + COMP_W +: COMP_W];
	assign in_b = s_tdata[IDX_W + 2 * COMP_W +: COMP_W];
	assign in_range = {1'b0, in_idx} < (IDX_W + 1)'(PALETTE_ENTRIES);
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = out_free && ((state_q == ST_LOOK) || (state_q == ST_DONE));

	assign ram_we = acc && (in_op == OP_WRITE) && in_range;
	assign ram_wdata = {in_r & COMP_MASK, in_g & COMP_MASK, in_b & COMP_MASK};
	assign ram_re = (acc && (in_op == OP_LOOKUP)) || (state_q == ST_SEARCH);
	assign ram_raddr = (state_q == ST_SEARCH) ? cnt_q : in_idx[PAL_AW-1:0];

	pncs_ram #(
		.WIDTH(RGB_W),
		.DEPTH(PALETTE_ENTRIES)
	) u_palette (
		.clk  (clk),
		.we   (ram_we),
		.waddr(in_idx[PAL_AW-1:0]),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// entries never written read as black
	assign pal_s1 = vld_s1 ? ram_rdata : '0;
	assign sum_s2 = DIST_W'(sqr_s2) + DIST_W'(sqg_s2) + DIST_W'(sqb_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ram_we) begin
			vld_q[in_idx[PAL_AW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			act_s1 <= 1'b0;
			last_s1 <= 1'b0;
			act_s2 <= 1'b0;
			last_s2 <= 1'b0;
			first_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (ram_re) begin
				vld_s1 <= vld_q[ram_raddr];
			end
			act_s1 <= (state_q == ST_SEARCH);
			last_s1 <= (state_q == ST_SEARCH) && (cnt_q == LAST_ENTRY);
			act_s2 <= act_s1;
			last_s2 <= last_s1;
			if (acc && (in_op == OP_SEARCH)) begin
				cnt_q <= '0;
				first_q <= 1'b1;
			end else begin
				if (state_q == ST_SEARCH) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (act_s2 && (first_q || (sum_s2 < best_dist_q))) begin
					first_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			look_idx_q <= in_idx;
			look_in_q <= in_range;
			key_r_q <= in_r;
			key_g_q <= in_g;
			key_b_q <= in_b;
		end
		idx_s1 <= cnt_q;
		idx_s2 <= idx_s1;
		rgb_s2 <= pal_s1;
		sqr_s2 <= sq_dist(key_r_q, pal_s1[2 * COMP_W +: COMP_W]);
		sqg_s2 <= sq_dist(key_g_q, pal_s1[COMP_W +: COMP_W]);
		sqb_s2 <= sq_dist(key_b_q, pal_s1[0 +: COMP_W]);
		// strict compare keeps the lowest index on ties
		if (act_s2 && (first_q || (sum_s2 < best_dist_q))) begin
			best_dist_q <= sum_s2;
			best_idx_q <= idx_s2;
			best_rgb_q <= rgb_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			m_tdata_q <= '0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						case (in_op)
							OP_LOOKUP: state_q <= ST_LOOK;
							OP_SEARCH: state_q <= ST_SEARCH;
							default:   state_q <= ST_IDLE;
						endcase
					end
				end
				ST_LOOK: begin
					if (out_free) begin
						m_tdata_q <= OUT_DATA_W'({DIST_W'(0),
							look_in_q ? pal_s1[0 +: COMP_W] : COMP_W'(0),
							look_in_q ? pal_s1[COMP_W +: COMP_W] : COMP_W'(0),
							look_in_q ? pal_s1[2 * COMP_W +: COMP_W] : COMP_W'(0),
							look_idx_q});
						state_q <= ST_IDLE;
					end
				end
				ST_SEARCH: begin
					if (cnt_q == LAST_ENTRY) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (act_s2 && last_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tdata_q <= OUT_DATA_W'({best_dist_q,
							best_rgb_q[0 +: COMP_W],
							best_rgb_q[COMP_W +: COMP_W],
							best_rgb_q[2 * COMP_W +: COMP_W],
							IDX_W'(best_idx_q)});
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	`PNCS_ASSERT_NOW(a_write_only_idle, ram_we, state_q == ST_IDLE)
	`PNCS_ASSERT_NEXT(a_last_compare_done, act_s2 && last_s2, state_q == ST_DONE)
	`PNCS_ASSERT_NOW(a_done_pipe_empty, state_q == ST_DONE, !act_s1 && !act_s2)
	`PNCS_ASSERT_NOW(a_result_source, $rose(m_tvalid),
		$past(state_q == ST_DONE || state_q == ST_LOOK))

endmodule

// ===== design/pncs_ram.sv =====
module pncs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
